### design/sskd_pkg.sv
// Package for the sprite skip/copy decoder: queue item type, operation and
// command codes, configuration register indexes and the dimension clamp.
// No dependencies.
package sskd_pkg;

  localparam logic [7:0] CMD_SKIP = 8'hff;
  localparam logic [7:0] CMD_EOL  = 8'hfe;

  localparam logic [1:0] OP_LIT  = 2'd0;
  localparam logic [1:0] OP_SKIP = 2'd1;
  localparam logic [1:0] OP_EOL  = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  localparam int          DIM_W       = 13;
  localparam int          FRAME_W     = 25;
  localparam int          QUEUE_DEPTH = 4;
  localparam logic [12:0] DIM_MAX     = 13'd4096;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic [DIM_W-1:0]   eff_w;
    logic [DIM_W-1:0]   eff_h;
    logic [FRAME_W-1:0] frame;
    logic               rearm;
  } cfg_t;

  function automatic logic [12:0] eff_dim(input logic [12:0] v);
    logic [12:0] r;
    r = v;
    if (v == 13'd0) begin
      r = 13'd1;
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end
    return r;
  endfunction

endpackage

### design/sskd_front.sv
// Front end of the sprite decoder: accepts stream bytes, tracks the command
// phase and pushes skip, end-of-line and literal operations to the queue.
// Depends on sskd_pkg.
module sskd_front import sskd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rearm_i,
  input  logic       block_i,
  input  logic       full_i,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // stream_byte[7:0]
  output logic       push_o,
  output op_t        item_o
);

  localparam logic [1:0] PH_CMD  = 2'd0;
  localparam logic [1:0] PH_SKIP = 2'd1;
  localparam logic [1:0] PH_LIT  = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] lit_left_r, lit_left_nxt;
  logic       accept;

  assign in_tready = !full_i && !block_i;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    phase_nxt    = phase_r;
    lit_left_nxt = lit_left_r;
    push_o       = 1'b0;
    item_o.op    = OP_LIT;
    item_o.data  = in_tdata;
    if (rearm_i) begin
      phase_nxt    = PH_CMD;
      lit_left_nxt = 8'd0;
    end else if (accept) begin
      case (phase_r)
        PH_SKIP: begin
          push_o    = 1'b1;
          item_o.op = OP_SKIP;
          phase_nxt = PH_CMD;
        end
        PH_LIT: begin
          push_o       = 1'b1;
          item_o.op    = OP_LIT;
          lit_left_nxt = lit_left_r - 8'd1;
          if (lit_left_r == 8'd1) begin
            phase_nxt = PH_CMD;
          end
        end
        default: begin
          if (in_tdata == CMD_SKIP) begin
            phase_nxt = PH_SKIP;
          end else if (in_tdata == CMD_EOL) begin
            push_o    = 1'b1;
            item_o.op = OP_EOL;
          end else begin
            lit_left_nxt = in_tdata;
            phase_nxt    = (in_tdata != 8'd0) ? PH_LIT : PH_CMD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CMD;
      lit_left_r <= 8'd0;
    end else begin
      phase_r    <= phase_nxt;
      lit_left_r <= lit_left_nxt;
    end
  end

endmodule

### design/sskd_fifo.sv
// Short operation queue between the front and back ends of the decoder,
// with a flush on rearm. No dependencies.
module sskd_fifo #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             flush_i,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             valid_o,
  output logic             full_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign valid_o = (count_r != '0);
  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign rdata_o = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (flush_i) begin
      wr_ptr_nxt = '0;
      rd_ptr_nxt = '0;
      count_nxt  = '0;
    end else begin
      if (do_push) begin
        wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && !flush_i) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("queue pushed while full");

endmodule

### design/sskd_back.sv
// Back end of the sprite decoder: executes queued operations against the
// write position, column and row counters and drives the output register.
// Depends on sskd_pkg.
module sskd_back import sskd_pkg::*; #(
  parameter int ADDR_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg_i,
  input  logic        q_valid_i,
  input  op_t         q_item_i,
  output logic        q_pop_o,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // pixel_address[23:0], pixel_value[31:24],
                                  // out_of_frame[32], zero fill[39:33]
  output logic        out_tuser   // kind
);

  localparam int CW = (ADDR_BITS > FRAME_W) ? ADDR_BITS : FRAME_W;

  localparam logic BK_RUN  = 1'b0;
  localparam logic BK_WRAP = 1'b1;

  logic                 state_r, state_nxt;
  logic [ADDR_BITS-1:0] pos_r, pos_nxt;
  logic [DIM_W-1:0]     col_r, col_nxt;
  logic [11:0]          rows_r, rows_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [23:0] out_addr_r, out_addr_nxt;
  logic [7:0]  out_val_r, out_val_nxt;
  logic        out_oof_r, out_oof_nxt;

  logic             adv;
  logic [CW-1:0]    pos_ext;
  logic [CW-1:0]    pos_sum;
  logic [DIM_W-1:0] col_sum;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] col_diff;
  logic [11:0]      rows_load;

  assign adv       = !out_valid_r || out_tready;
  assign pos_ext   = CW'(pos_r);
  assign col_sum   = col_r + {5'd0, q_item_i.data};
  assign col_inc   = col_r + DIM_W'(1);
  assign col_diff  = col_r - cfg_i.eff_w;
  assign rows_load = 12'(cfg_i.eff_h - DIM_W'(1));

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    col_nxt       = col_r;
    rows_nxt      = rows_r;
    q_pop_o       = 1'b0;
    pos_sum       = pos_ext;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_addr_nxt  = out_addr_r;
    out_val_nxt   = out_val_r;
    out_oof_nxt   = out_oof_r;
    if (cfg_i.rearm) begin
      state_nxt = BK_RUN;
      pos_nxt   = '0;
      col_nxt   = '0;
      rows_nxt  = rows_load;
    end else begin
      case (state_r)
        BK_WRAP: begin
          col_nxt = col_diff;
          if (col_diff < cfg_i.eff_w) begin
            state_nxt = BK_RUN;
          end
        end
        default: begin
          if (q_valid_i && adv) begin
            q_pop_o = 1'b1;
            case (q_item_i.op)
              OP_LIT: begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = 1'b0;
                out_addr_nxt  = pos_ext[23:0];
                out_val_nxt   = q_item_i.data;
                out_oof_nxt   = (pos_ext >= CW'(cfg_i.frame));
                pos_sum       = pos_ext + CW'(1);
                pos_nxt       = pos_sum[ADDR_BITS-1:0];
                col_nxt       = (col_inc == cfg_i.eff_w) ? '0 : col_inc;
              end
              OP_SKIP: begin
                pos_sum = pos_ext + CW'(q_item_i.data);
                pos_nxt = pos_sum[ADDR_BITS-1:0];
                col_nxt = col_sum;
                if (col_sum >= cfg_i.eff_w) begin
                  state_nxt = BK_WRAP;
                end
              end
              OP_EOL: begin
                if (rows_r == 12'd0) begin
                  out_valid_nxt = 1'b1;
                  out_kind_nxt  = 1'b1;
                  out_addr_nxt  = 24'd0;
                  out_val_nxt   = 8'd0;
                  out_oof_nxt   = 1'b0;
                  pos_nxt       = '0;
                  col_nxt       = '0;
                  rows_nxt      = rows_load;
                end else begin
                  rows_nxt = rows_r - 12'd1;
                  pos_sum  = pos_ext + CW'(cfg_i.eff_w - col_r);
                  pos_nxt  = pos_sum[ADDR_BITS-1:0];
                  col_nxt  = '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      pos_r       <= '0;
      col_r       <= '0;
      rows_r      <= 12'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      col_r       <= col_nxt;
      rows_r      <= rows_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_addr_r <= out_addr_nxt;
    out_val_r  <= out_val_nxt;
    out_oof_r  <= out_oof_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {7'd0, out_oof_r, out_val_r, out_addr_r};

  a_wrap_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_WRAP && !cfg_i.rearm) |-> col_r >= cfg_i.eff_w)
    else $error("column wrap entered with column inside the row");

  a_run_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RUN && !cfg_i.rearm && !$past(cfg_i.rearm)) |-> col_r < cfg_i.eff_w)
    else $error("column left outside the row");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r) |-> (out_addr_r == 24'd0 && out_val_r == 8'd0 && !out_oof_r))
    else $error("done result carries pixel data");

endmodule

### design/sprite_skip_copy_decoder.sv
// Top level of the sprite skip/copy decoder: configuration registers, front
// end, operation queue and back end. Depends on sskd_pkg, sskd_front,
// sskd_fifo and sskd_back.
//
// The block takes one sprite byte per cycle, unless held off, into its front
// end, which keeps the command phase and queues skip, end-of-line and
// literal operations in a four-entry queue. The back end executes one
// operation per cycle unless its output stalls or a column wrap runs, so
// literals and commands sustain one byte per cycle. A skip whose column sum
// reaches the row width enters the column wrap loop, which subtracts the
// width until the column lies inside the row. Results pass the queue and the
// output register; a waiting result stops no bytes until the queue fills.
// A full queue, an offered write or a set rearm holds off input. A width
// or height write rearms the decoder; no other clearing pass is needed.
module sprite_skip_copy_decoder import sskd_pkg::*; #(
  parameter int ADDR_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // stream_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // pixel_address[23:0], pixel_value[31:24],
                                  // out_of_frame[32], zero fill[39:33]
  output logic        out_tuser   // kind
);

  logic [DIM_W-1:0]   eff_w_r, eff_w_nxt;
  logic [DIM_W-1:0]   eff_h_r, eff_h_nxt;
  logic [FRAME_W-1:0] frame_r;
  logic               rearm_r, rearm_nxt;
  logic               cfg_accept;
  cfg_t               cfg;

  logic             push;
  op_t              push_item;
  logic [$bits(op_t)-1:0] q_rdata;
  logic             q_valid;
  logic             q_full;
  logic             q_pop;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;

  always_comb begin
    eff_w_nxt = eff_w_r;
    eff_h_nxt = eff_h_r;
    rearm_nxt = 1'b0;
    if (cfg_accept) begin
      case (cfg_index)
        CFG_WIDTH: begin
          eff_w_nxt = eff_dim(cfg_data);
          rearm_nxt = 1'b1;
        end
        CFG_HEIGHT: begin
          eff_h_nxt = eff_dim(cfg_data);
          rearm_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= DIM_W'(1);
      eff_h_r <= DIM_W'(1);
      frame_r <= FRAME_W'(1);
      rearm_r <= 1'b0;
    end else begin
      eff_w_r <= eff_w_nxt;
      eff_h_r <= eff_h_nxt;
      frame_r <= FRAME_W'(eff_w_r * eff_h_r);
      rearm_r <= rearm_nxt;
    end
  end

  assign cfg.eff_w = eff_w_r;
  assign cfg.eff_h = eff_h_r;
  assign cfg.frame = frame_r;
  assign cfg.rearm = rearm_r;

  sskd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .rearm_i   (rearm_r),
    .block_i   (cfg_valid || rearm_r),
    .full_i    (q_full),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push_o    (push),
    .item_o    (push_item)
  );

  sskd_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .flush_i (rearm_r),
    .push_i  (push),
    .wdata_i (push_item),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  sskd_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .q_valid_i  (q_valid),
    .q_item_i   (op_t'(q_rdata)),
    .q_pop_o    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### verif/sskd_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the sprite skip/copy decoder: follows register writes and
// accepted sprite bytes, predicts pixel writes and done results and checks
// every accepted result against them. Depends on sskd_pkg.
module sskd_checker import sskd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tuser,
  output int          outstanding,
  output int          mismatches
);

  typedef enum logic [1:0] {
    PH_CMD,
    PH_SKIP,
    PH_LIT
  } phase_e;

  typedef struct packed {
    logic        kind;
    logic [23:0] addr;
    logic [7:0]  value;
    logic        oof;
  } pixel_t;

  pixel_t      pixel_q[$];
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  phase_e      phase;
  logic [7:0]  lits_left;
  logic [23:0] wr_pos;
  int unsigned column;
  int unsigned rows_left;
  int          err_cnt = 0;

  function automatic int unsigned clamp_dim(input logic [12:0] v);
    if (v == 13'd0) return 1;
    if (v > 13'd4096) return 4096;
    return v;
  endfunction

  task automatic restart();
    phase     = PH_CMD;
    lits_left = 8'd0;
    wr_pos    = 24'd0;
    column    = 0;
    rows_left = clamp_dim(height_reg) - 1;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int unsigned w;
    logic [24:0] frame;
    pixel_t      p;
    int unsigned n;
    w     = clamp_dim(width_reg);
    frame = 25'(w * clamp_dim(height_reg));
    case (phase)
      PH_SKIP: begin
        wr_pos = wr_pos + 24'(b);
        column = (column + b) % w;
        phase  = PH_CMD;
      end
      PH_LIT: begin
        p.kind  = 1'b0;
        p.addr  = wr_pos;
        p.value = b;
        p.oof   = ({1'b0, wr_pos} >= frame);
        pixel_q.push_back(p);
        wr_pos = wr_pos + 24'd1;
        column = column + 1;
        if (column >= w) column = 0;
        lits_left = lits_left - 8'd1;
        if (lits_left == 8'd0) phase = PH_CMD;
      end
      default: begin
        if (b == CMD_SKIP) begin
          phase = PH_SKIP;
        end else if (b == CMD_EOL) begin
          if (rows_left == 0) begin
            restart();
            p      = '0;
            p.kind = 1'b1;
            pixel_q.push_back(p);
          end else begin
            rows_left = rows_left - 1;
            wr_pos    = wr_pos + 24'(w - column);
            column    = 0;
          end
        end else begin
          n         = b[0] + 2 * b[1] + 4 * b[7:2];
          lits_left = 8'(n);
          phase     = (n != 0) ? PH_LIT : PH_CMD;
        end
      end
    endcase
  endtask

  task automatic check_result();
    pixel_t e;
    if (pixel_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10) begin
        $display("%0t: result with none expected: kind %0b data %h", $time, out_tuser,
                 out_tdata);
      end
    end else begin
      e = pixel_q.pop_front();
      if (out_tuser !== e.kind || out_tdata[23:0] !== e.addr ||
          out_tdata[31:24] !== e.value || out_tdata[32] !== e.oof ||
          out_tdata[39:33] !== 7'd0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("%0t: expected kind %0b addr %h value %h oof %0b", $time, e.kind,
                   e.addr, e.value, e.oof);
          $display("%0t: got      kind %0b addr %h value %h oof %0b fill %h", $time,
                   out_tuser, out_tdata[23:0], out_tdata[31:24], out_tdata[32],
                   out_tdata[39:33]);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = 13'd1;
      height_reg = 13'd1;
      restart();
      pixel_q.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) begin
          width_reg = cfg_data;
          restart();
        end else if (cfg_index == CFG_HEIGHT) begin
          height_reg = cfg_data;
          restart();
        end
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata);
    end
    outstanding <= pixel_q.size();
    mismatches  <= err_cnt;
  end

endmodule

### verif/tb_sprite_skip_copy_decoder.sv
`timescale 1ns / 1ps
// Testbench top for the sprite skip/copy decoder: clock, reset, sprite byte
// stimulus, register writes, result back-pressure and the verdict. Depends on
// sskd_pkg, sprite_skip_copy_decoder and sskd_checker.
module tb_sprite_skip_copy_decoder;
  import sskd_pkg::*;

  localparam logic [1:0] CFG_SPARE      = 2'd3;
  localparam int         SETTLE_CYCLES  = 1100;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         WATCHDOG_LIMIT = 20000;
  localparam int         IDLE_PCT       = 21;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        hold_go;
  logic        idle_on;
  int          hold_left    = 0;
  int          quiet_cycles = 0;
  int          bytes_sent   = 0;
  int          outstanding;
  int          mismatches;
  logic [7:0]  stim_q[$];

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  sprite_skip_copy_decoder #(
    .ADDR_BITS(24)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  sskd_checker u_pixel_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .outstanding(outstanding),
    .mismatches (mismatches)
  );

  always @(posedge clk) begin
    if (hold_go) begin
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_queued();
    while (stim_q.size() != 0) send_byte(stim_q.pop_front());
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dims(input logic [12:0] w, input logic [12:0] h);
    drain();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_WIDTH, w);
      write_reg(CFG_HEIGHT, h);
    end else begin
      write_reg(CFG_HEIGHT, h);
      write_reg(CFG_WIDTH, w);
    end
    cfg_valid <= 1'b0;
  endtask

  // One row of a sprite: copies, skips and the odd stray byte, usually
  // closed by an end-of-line command.
  task automatic emit_row();
    int         segs;
    int         pick;
    int         n;
    logic [7:0] c;
    segs = $urandom_range(0, 4);
    repeat (segs) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 19) == 0) c = 8'($urandom_range(0, 253));
        else c = 8'($urandom_range(0, 15));
        send_byte(c);
        n = int'(c[0]) + 2 * int'(c[1]) + 4 * int'(c[7:2]);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        send_byte(CMD_SKIP);
        if ($urandom_range(0, 9) < 7) send_byte(8'($urandom_range(0, 15)));
        else send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) != 0) send_byte(CMD_EOL);
  endtask

  task automatic run_phase(input int n_items);
    int target;
    target = bytes_sent + n_items;
    while (bytes_sent < target) emit_row();
  endtask

  function automatic logic [12:0] pick_width();
    if ($urandom_range(0, 3) == 0) return 13'($urandom_range(0, 8191));
    return 13'($urandom_range(1, 24));
  endfunction

  function automatic logic [12:0] pick_height();
    if ($urandom_range(0, 4) == 0) return 13'($urandom_range(0, 8191));
    return 13'($urandom_range(1, 6));
  endfunction

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data  = 13'd0;
    in_tvalid = 1'b0;
    in_tdata  = 8'd0;
    hold_go   = 1'b0;
    idle_on   = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The decoder is at rest after reset, so a write to the spare index
    // must leave every prediction unchanged.
    write_reg(CFG_SPARE, 13'h1fff);
    cfg_valid <= 1'b0;

    set_dims(13'd0, 13'd0);
    stim_q = '{8'h00, 8'h01, 8'h00, CMD_SKIP, 8'hff, 8'h02, 8'hff, 8'h80,
               8'h04, 8'h7f, 8'h55, 8'haa, 8'h01, CMD_EOL};
    send_queued();

    set_dims(13'd1, 13'd2);
    stim_q = '{CMD_EOL, 8'h02, 8'h33, 8'h44, CMD_EOL};
    send_queued();

    // Largest frame: walk down a few whole rows, skip along one and copy a
    // run of pixels into it.
    set_dims(13'h1fff, 13'h1fff);
    repeat (8) send_byte(CMD_EOL);
    repeat (2) begin
      send_byte(CMD_SKIP);
      send_byte(8'hff);
    end
    send_byte(8'h1f);
    repeat (31) send_byte(8'($urandom_range(0, 255)));
    send_byte(CMD_EOL);

    set_dims(13'd1, 13'd1);
    run_phase(150);
    set_dims(13'd4096, 13'd2);
    run_phase(150);
    set_dims(13'd0, 13'h1fff);
    run_phase(150);
    set_dims(13'd4097, 13'd0);
    run_phase(150);

    idle_on <= 1'b0;
    set_dims(13'd7, 13'd3);
    run_phase(170);
    idle_on <= 1'b1;

    set_dims(13'($urandom_range(1, 40)), 13'($urandom_range(1, 6)));
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    run_phase(170);

    repeat (3) begin
      set_dims(pick_width(), pick_height());
      run_phase(180);
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
